@@ rtl/oat_pkg.sv @@
// Shared types, codes and defaults for the ordered array table.
package oat_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam logic [1:0] KIND_INSERT    = 2'd0;
   localparam logic [1:0] KIND_FIND      = 2'd1;
   localparam logic [1:0] KIND_REMOVE    = 2'd2;
   localparam logic [1:0] KIND_UNORDERED = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [2:0] CELL_HOLD = 3'd0;
   localparam logic [2:0] CELL_LOAD = 3'd1;
   localparam logic [2:0] CELL_UP   = 3'd2;
   localparam logic [2:0] CELL_DOWN = 3'd3;
   localparam logic [2:0] CELL_LAST = 3'd4;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [2:0] match_index;
      logic [3:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         sel;
      logic signed [31:0] load_value;
      logic signed [31:0] last_value;
      logic signed [31:0] search_value;
   } cell_ctrl_type;

endpackage

@@ rtl/oat_cell.sv @@
// One storage cell of the table: holds an entry, shifts with its neighbors, compares.
module oat_cell (
   input  logic                  clock,
   input  oat_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]    from_lower,
   input  logic signed [31:0]    from_upper,
   output logic signed [31:0]    entry,
   output logic                  match
);
   import oat_pkg::*;

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   always_comb begin
      unique case (ctrl.sel)
         CELL_LOAD: entry_in = ctrl.load_value;
         CELL_UP:   entry_in = from_lower;
         CELL_DOWN: entry_in = from_upper;
         CELL_LAST: entry_in = ctrl.last_value;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == ctrl.search_value);

endmodule

@@ rtl/oat_first_hit.sv @@
// Priority encoder that finds the lowest set hit bit.
module oat_first_hit #(
   parameter int DEPTH = oat_pkg::DEPTH_DEFAULT,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic [DEPTH-1:0] hits,
   output logic             any,
   output logic [IW-1:0]    index
);
   always_comb begin
      any   = 1'b0;
      index = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hits[i]) begin
            any   = 1'b1;
            index = IW'(i);
         end
      end
   end

endmodule

@@ rtl/ordered_array_table.sv @@
// Top level of the ordered array table: a chain of entry cells with a two-stage result path.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | oat_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | oat_pkg::rsp_type
//
// One request per cycle unless req_stall is raised; each result passes the request stage, then the result stage.
// Cells update at the transfer edge; the find hit vector is encoded in the next stage.
// Reset clears the occupancy count and both stage valids; entries are not cleared.
// A stalled result holds; the input stalls only when both stages are full.
module ordered_array_table #(
   parameter int DEPTH = oat_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oat_pkg::rsp_type rsp_payload
);
   import oat_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = (CW > 3) ? CW : 3;

   logic [CW-1:0]      fill_ff, fill_in;
   logic               a_valid_ff, a_valid_in;
   logic [1:0]         a_status_ff, a_status_in;
   logic               a_find_ff;
   logic [DEPTH-1:0]   a_hits_ff, a_hits_in;
   logic [CW-1:0]      a_occ_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept, a_move, op_ok;
   logic [PW-1:0]      pos_x, fill_x;
   logic [CW-1:0]      fill_m1;
   logic signed [31:0] entry [DEPTH];
   logic [DEPTH-1:0]   match;
   cell_ctrl_type      cell_ctrl [DEPTH];
   logic               hit_any;
   logic [IW-1:0]      hit_index;
   logic [IW+2:0]      index_wide;
   logic [CW+3:0]      occ_wide;

   assign a_move    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_x   = PW'(req_payload.position);
   assign fill_x  = PW'(fill_ff);
   assign fill_m1 = fill_ff - CW'(1);

   always_comb begin
      unique case (req_payload.kind)
         KIND_INSERT: begin
            if (pos_x > fill_x) begin
               a_status_in = STATUS_RANGE;
            end else if (fill_ff == CW'(DEPTH)) begin
               a_status_in = STATUS_FULL;
            end else begin
               a_status_in = STATUS_OK;
            end
         end
         KIND_FIND: a_status_in = STATUS_OK;
         default: a_status_in = (pos_x >= fill_x) ? STATUS_RANGE : STATUS_OK;
      endcase
      op_ok = accept && (a_status_in == STATUS_OK);
   end

   always_comb begin
      fill_in = fill_ff;
      if (op_ok) begin
         unique case (req_payload.kind)
            KIND_INSERT: fill_in = fill_ff + CW'(1);
            KIND_FIND:   fill_in = fill_ff;
            default:     fill_in = fill_m1;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i].sel          = CELL_HOLD;
         cell_ctrl[i].load_value   = req_payload.value;
         cell_ctrl[i].last_value   = entry[fill_m1[IW-1:0]];
         cell_ctrl[i].search_value = req_payload.value;
         if (op_ok) begin
            unique case (req_payload.kind)
               KIND_INSERT: begin
                  if (PW'(i) == pos_x) begin
                     cell_ctrl[i].sel = CELL_LOAD;
                  end else if (PW'(i) > pos_x && PW'(i) <= fill_x) begin
                     cell_ctrl[i].sel = CELL_UP;
                  end
               end
               KIND_REMOVE: begin
                  if (PW'(i) >= pos_x && PW'(i) < PW'(fill_m1)) begin
                     cell_ctrl[i].sel = CELL_DOWN;
                  end
               end
               KIND_UNORDERED: begin
                  if (PW'(i) == pos_x) begin
                     cell_ctrl[i].sel = CELL_LAST;
                  end
               end
               default: cell_ctrl[i].sel = CELL_HOLD;
            endcase
         end
         a_hits_in[i] = match[i] && (PW'(i) < fill_x);
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      oat_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .from_lower (entry[(g > 0) ? g - 1 : g]),
         .from_upper (entry[(g < DEPTH - 1) ? g + 1 : g]),
         .entry      (entry[g]),
         .match      (match[g])
      );
   end

   oat_first_hit #(.DEPTH(DEPTH)) u_first_hit (
      .hits  (a_hits_ff),
      .any   (hit_any),
      .index (hit_index)
   );

   assign index_wide = {3'b000, hit_index};
   assign occ_wide   = {4'b0000, a_occ_ff};

   always_comb begin
      rsp_in.status      = a_status_ff;
      rsp_in.found       = a_find_ff && hit_any;
      rsp_in.match_index = (a_find_ff && hit_any) ? index_wide[2:0] : 3'd0;
      rsp_in.occupancy   = occ_wide[3:0];
   end

   always_comb begin
      a_valid_in   = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      rsp_valid_in = a_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_status_ff <= a_status_in;
         a_find_ff   <= (req_payload.kind == KIND_FIND);
         a_hits_ff   <= a_hits_in;
         a_occ_ff    <= fill_in;
      end
      if (a_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("occupancy count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      op_ok && req_payload.kind == KIND_INSERT |=> fill_ff == $past(fill_ff) + CW'(1))
      else $error("successful insert did not grow the table");

   a_find_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.kind == KIND_FIND |=> $stable(fill_ff))
      else $error("find changed the occupancy");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !a_move |=> a_valid_ff)
      else $error("blocked request stage lost its item");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.status == STATUS_OK)
      else $error("found flag with a failing status");

endmodule
